@@ hdl/bcwc_pkg.sv @@
`timescale 1ns / 1ps
// bcwc_pkg: shared types and constants of the window code coverage unit
// no dependencies

package bcwc_pkg;

	// configuration register width and its reset value
	localparam int unsigned CFG_W = 5;
	localparam logic [CFG_W-1:0] K_RESET = 5'd2;

	// string tag kept per bitmap entry; tag zero marks a cleared entry
	localparam int unsigned EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	localparam int unsigned COUNT_W = 17;

	typedef struct packed {
		logic bit_in;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] distinct_count;
		logic               all_present;
		logic               end_of_string;
	} out_item_t;

endpackage

@@ hdl/bcwc_ram.sv @@
`timescale 1ns / 1ps
// bcwc_ram: generic single write, single read ram with registered read data
// read during write to the same address returns the old data

module bcwc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/bcwc_fifo.sv @@
`timescale 1ns / 1ps
// bcwc_fifo: small flop based first-in first-out queue
// no package dependencies

module bcwc_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/bcwc_front.sv @@
`timescale 1ns / 1ps
// bcwc_front: code length register, sliding window and fill tracking
// uses bcwc_pkg; feeds classified beats into the middle queue

module bcwc_front import bcwc_pkg::*; #(
	parameter int unsigned MAX_K = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_W-1:0]            cfg_data,
	input  logic                        push,
	output logic                        full,
	input  in_item_t                    item,
	input  logic                        q_full,
	input  logic                        clearing,
	output logic                        q_push,
	output logic [MAX_K+2+CFG_W-1:0]    q_data
);

	logic [CFG_W-1:0] window_len_q;
	logic [MAX_K-1:0] window_q;
	logic [CFG_W-1:0] bits_q;

	logic [CFG_W-1:0] k_eff;
	logic [MAX_K-1:0] mask;
	logic [MAX_K-1:0] window_next;
	logic [CFG_W-1:0] bits_next;
	logic             mark;

	assign cfg_ready = 1'b1;

	// zero acts as one, anything above the bitmap size is clamped
	always_comb begin
		if (window_len_q == '0) begin
			k_eff = CFG_W'(1);
		end else if (window_len_q > CFG_W'(MAX_K)) begin
			k_eff = CFG_W'(MAX_K);
		end else begin
			k_eff = window_len_q;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			mask[i] = (CFG_W'(i) < k_eff);
		end
	end

	assign window_next = ((window_q << 1) | MAX_K'(item.bit_in)) & mask;
	assign bits_next   = (bits_q < k_eff) ? bits_q + 1'b1 : bits_q;
	assign mark        = (bits_next >= k_eff);

	assign full   = q_full || clearing;
	assign q_push = push && !full;
	assign q_data = {window_next, mark, item.last, k_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= K_RESET;
			window_q     <= '0;
			bits_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_len_q <= cfg_data;
			end
			if (q_push) begin
				if (item.last) begin
					window_q <= '0;
					bits_q   <= '0;
				end else begin
					window_q <= window_next;
					bits_q   <= bits_next;
				end
			end
		end
	end

endmodule

@@ hdl/bcwc_back.sv @@
`timescale 1ns / 1ps
// bcwc_back: tagged bitmap read-modify-write, distinct counter, tag sweep
// uses bcwc_pkg and bcwc_ram

module bcwc_back import bcwc_pkg::*; #(
	parameter int unsigned MAX_K     = 16,
	parameter int unsigned OUT_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  logic [MAX_K+2+CFG_W-1:0]       q_data,
	output logic                           q_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                           res_push,
	output out_item_t                      res,
	output logic                           clearing
);

	localparam int unsigned CNT_W = MAX_K + 1;
	localparam int unsigned OCW   = $clog2(OUT_DEPTH + 1);

	// head of the middle queue
	logic [MAX_K-1:0] q_addr;
	logic             q_mark;
	logic             q_last;
	logic [CFG_W-1:0] q_k;

	logic             s1_v;
	logic [MAX_K-1:0] addr_s1;
	logic             mark_s1;
	logic             last_s1;
	logic [CFG_W-1:0] k_s1;

	logic [EPOCH_W-1:0] epoch_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               fwd_v_q;
	logic [MAX_K-1:0]   fwd_addr_q;
	logic               sweep_q;
	logic [MAX_K-1:0]   sweep_addr_q;

	logic               wrap_now;
	logic               issue;
	logic [EPOCH_W-1:0] rd_tag;
	logic               seen;
	logic               mark_new;
	logic [CNT_W-1:0]   cnt_new;
	logic               ram_we;
	logic [MAX_K-1:0]   ram_waddr;
	logic [EPOCH_W-1:0] ram_wdata;

	assign {q_addr, q_mark, q_last, q_k} = q_data;

	// last beat of the final tag value: whole bitmap gets swept next
	assign wrap_now = s1_v && last_s1 && (epoch_q == EPOCH_LAST);

	// room for the beat in s1 and this one in the result queue
	assign issue = !q_empty && !sweep_q && !wrap_now &&
		(({1'b0, out_count} + (OCW + 1)'(s1_v)) < (OCW + 1)'(OUT_DEPTH));
	assign q_pop = issue;

	// tag from ram, or the write of the previous cycle not yet visible
	assign seen     = (rd_tag == epoch_q) || (fwd_v_q && (fwd_addr_q == addr_s1));
	assign mark_new = s1_v && mark_s1 && !seen;
	assign cnt_new  = cnt_q + CNT_W'(mark_new);

	always_comb begin
		if (sweep_q) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_addr_q;
			ram_wdata = EPOCH_CLEAR;
		end else begin
			ram_we    = mark_new;
			ram_waddr = addr_s1;
			ram_wdata = epoch_q;
		end
	end

	bcwc_ram #(
		.WIDTH (EPOCH_W),
		.DEPTH (2 ** MAX_K)
	) u_seen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (q_addr),
		.rdata (rd_tag)
	);

	assign res_push           = s1_v;
	assign res.distinct_count = COUNT_W'(cnt_new);
	assign res.all_present    = (cnt_new == (CNT_W'(1) << k_s1));
	assign res.end_of_string  = last_s1;
	assign clearing           = sweep_q;

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= q_addr;
			mark_s1 <= q_mark;
			last_s1 <= q_last;
			k_s1    <= q_k;
		end
		fwd_addr_q <= addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v         <= 1'b0;
			epoch_q      <= EPOCH_FIRST;
			cnt_q        <= '0;
			fwd_v_q      <= 1'b0;
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else begin
			s1_v    <= issue;
			fwd_v_q <= mark_new && !last_s1;
			if (s1_v) begin
				if (last_s1) begin
					cnt_q   <= '0;
					epoch_q <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + 1'b1;
				end else begin
					cnt_q <= cnt_new;
				end
			end
			if (wrap_now) begin
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
			end else if (sweep_q) begin
				sweep_addr_q <= sweep_addr_q + 1'b1;
				if (sweep_addr_q == '1) begin
					sweep_q <= 1'b0;
				end
			end
		end
	end

	a_no_issue_in_sweep : assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !issue)
		else $error("beat issued during bitmap sweep");

	a_epoch_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != EPOCH_CLEAR)
		else $error("string tag equals the cleared tag");

	a_count_cleared : assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && last_s1) |=> (cnt_q == '0))
		else $error("distinct counter not cleared after end of string");

	a_result_room : assert property (@(posedge clk) disable iff (!arst_n)
		s1_v |-> (out_count < OCW'(OUT_DEPTH)))
		else $error("result queue overflow");

	a_wrap_sweeps : assert property (@(posedge clk) disable iff (!arst_n)
		wrap_now |=> (sweep_q && !s1_v))
		else $error("tag wrap without bitmap sweep");

endmodule

@@ hdl/binary_code_window_coverage_unit.sv @@
`timescale 1ns / 1ps
// binary_code_window_coverage_unit: top level of the window code coverage unit
// uses bcwc_pkg, bcwc_front, bcwc_fifo, bcwc_back (which holds bcwc_ram)

// The unit takes a bit string one bit per beat (item.bit_in, with item.last on
// the final bit) and, for every beat, returns one result: how many distinct
// k-bit codes the sliding window has shown so far in the current string, and
// whether all 2^k codes are present; end_of_string echoes last, and after that
// beat the window, bitmap and count start over. k comes from the single
// configuration register (0 acts as 1, values above MAX_K act as MAX_K); the
// user must write it only while the unit is idle, the unit does not enforce
// this. Both sides look like queues: an input beat is taken when push is high
// and full is low, a result is taken when pop is high and empty is low. The
// unit sustains one beat per clock while no sweep runs and results are taken;
// a beat passes the middle queue, the back stage register and the result
// queue; the limit is the single read-modify-write of the code bitmap ram
// per beat. The bitmap keeps a small string tag per code instead of a bit, so
// starting a new string costs nothing; after reset, and once every 255 strings
// when the tag wraps, the whole bitmap is swept; full stays high in the sweep.

module binary_code_window_coverage_unit import bcwc_pkg::*; #(
	parameter int unsigned MAX_K     = 16,
	parameter int unsigned MID_DEPTH = 2,
	parameter int unsigned OUT_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration: code length
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	// input beats
	input  logic             push,
	output logic             full,
	input  in_item_t         item,
	// result beats
	output logic             empty,
	input  logic             pop,
	output out_item_t        result
);

	// window value, mark flag, last flag and effective k per beat
	localparam int unsigned MID_W = MAX_K + 2 + CFG_W;
	localparam int unsigned OCW   = $clog2(OUT_DEPTH + 1);

	logic             mid_push;
	logic [MID_W-1:0] mid_wdata;
	logic             mid_pop;
	logic [MID_W-1:0] mid_rdata;
	logic             mid_full;
	logic             mid_empty;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

	logic             res_push;
	out_item_t        res_data;
	logic             res_full;
	logic [OCW-1:0]   res_count;
	logic             clearing;

	// front: register, window shift, fill count, classify beat
	bcwc_front #(
		.MAX_K (MAX_K)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.q_full    (mid_full),
		.clearing  (clearing),
		.q_push    (mid_push),
		.q_data    (mid_wdata)
	);

	// short queue so front and back stall independently
	bcwc_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	// back: bitmap lookup and update, distinct count, verdict
	bcwc_back #(
		.MAX_K     (MAX_K),
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (mid_empty),
		.q_data    (mid_rdata),
		.q_pop     (mid_pop),
		.out_count (res_count),
		.res_push  (res_push),
		.res       (res_data),
		.clearing  (clearing)
	);

	// result queue; the back only issues when there is room, so it never drops
	bcwc_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.pop    (pop),
		.rdata  (result),
		.full   (res_full),
		.empty  (empty),
		.count  (res_count)
	);

	a_mid_bounded : assert property (@(posedge clk) disable iff (!arst_n)
		mid_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
		else $error("middle queue count out of range");

	a_no_res_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		res_full |-> !res_push)
		else $error("result pushed into full queue");

	a_full_in_sweep : assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("input open during bitmap sweep");

endmodule
